FILE: design/ipv4_udp_header_generator_core_assert.svh
// Assertion macros shared by the header generator modules.
// Each macro expects the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef IPV4_UDP_HEADER_GENERATOR_CORE_ASSERT_SVH
`define IPV4_UDP_HEADER_GENERATOR_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define IUHG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define IUHG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: design/iuhg_pkg.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header generator package
// Payload types and header constants shared by the generator modules.
// ----------------------------------------------------------------------------
package iuhg_pkg;

    localparam int HDR_BYTES = 28;
    localparam int HDR_W     = HDR_BYTES * 8;
    localparam int CNT_W     = $clog2(HDR_BYTES);
    localparam int IP_WORDS  = 10;
    localparam int SUM_W     = 20;

    localparam logic [CNT_W-1:0] LAST_IDX    = CNT_W'(HDR_BYTES - 1);
    localparam logic [15:0]      MAX_PAYLOAD = 16'd65507;
    localparam logic [15:0]      IP_HDR_LEN  = 16'd28;
    localparam logic [15:0]      UDP_HDR_LEN = 16'd8;
    localparam logic [7:0]       VER_IHL     = 8'h45;
    localparam logic [15:0]      FLAG_DF     = 16'h4000;
    localparam logic [7:0]       TTL_VALUE   = 8'd64;
    localparam logic [7:0]       PROTO_UDP   = 8'd17;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } t_req;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } t_rsp;

endpackage

FILE: design/iuhg_hdr_build.sv
// ----------------------------------------------------------------------------
// Header builder
// Registers a request, assembles the 28 header bytes and the IPv4 word sum,
// and hands the finished header with its checksum to the serializer.
// ----------------------------------------------------------------------------
module iuhg_hdr_build (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  iuhg_pkg::t_req                i_in_data,
    input  logic [5:0]                    i_dscp,
    output logic                          o_hdr_vld,
    output logic [iuhg_pkg::HDR_W-1:0]    o_hdr,
    input  logic                          i_load
);

    logic                          r_s1_vld;
    iuhg_pkg::t_req                r_req;
    logic                          r_s2_vld;
    logic [iuhg_pkg::HDR_W-1:0]    r_hdr;
    logic [iuhg_pkg::SUM_W-1:0]    r_sum;
    logic [15:0]                   r_pid;

    logic                          s2_ready;
    logic                          s1_accept;
    logic                          s2_load;
    logic [15:0]                   len_sat;
    logic [15:0]                   tot_len;
    logic [15:0]                   udp_len;
    logic [iuhg_pkg::HDR_W-1:0]    n_hdr;
    logic [iuhg_pkg::SUM_W-1:0]    n_sum;
    logic [16:0]                   fold1;
    logic [15:0]                   fold2;
    logic [15:0]                   cksum;

    assign s2_ready   = !r_s2_vld || i_load;
    assign o_in_stall = r_s1_vld && !s2_ready;
    assign s1_accept  = i_in_valid && !o_in_stall;
    assign s2_load    = r_s1_vld && s2_ready;

    always_comb begin
        len_sat = (r_req.payload_length > iuhg_pkg::MAX_PAYLOAD) ?
                  iuhg_pkg::MAX_PAYLOAD : r_req.payload_length;
        tot_len = iuhg_pkg::IP_HDR_LEN + len_sat;
        udp_len = iuhg_pkg::UDP_HDR_LEN + len_sat;
        // Wire order, byte 0 in the top bits. Addresses go out low byte first.
        n_hdr = {iuhg_pkg::VER_IHL, {i_dscp, 2'b00}, tot_len, r_pid,
                 iuhg_pkg::FLAG_DF, iuhg_pkg::TTL_VALUE, iuhg_pkg::PROTO_UDP, 16'h0000,
                 r_req.source_address[7:0], r_req.source_address[15:8],
                 r_req.source_address[23:16], r_req.source_address[31:24],
                 r_req.dest_address[7:0], r_req.dest_address[15:8],
                 r_req.dest_address[23:16], r_req.dest_address[31:24],
                 r_req.source_port, r_req.dest_port, udp_len, 16'h0000};
        n_sum = '0;
        for (int w = 0; w < iuhg_pkg::IP_WORDS; w++) begin
            n_sum = n_sum + iuhg_pkg::SUM_W'(n_hdr[iuhg_pkg::HDR_W-1-16*w -: 16]);
        end
    end

    // End-around carry fold; two passes are enough for a 20-bit sum.
    always_comb begin
        fold1 = {1'b0, r_sum[15:0]} + 17'(r_sum[iuhg_pkg::SUM_W-1:16]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        cksum = ~fold2;
        o_hdr = r_hdr;
        o_hdr[iuhg_pkg::HDR_W-81 -: 16] = cksum;
    end

    assign o_hdr_vld = r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_pid    <= '0;
        end else begin
            if (s1_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s2_load) begin
                r_s1_vld <= 1'b0;
            end
            if (s2_load) begin
                r_s2_vld <= 1'b1;
                r_pid    <= r_pid + 16'd1;
            end else if (i_load) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_accept) begin
            r_req <= i_in_data;
        end
        if (s2_load) begin
            r_hdr <= n_hdr;
            r_sum <= n_sum;
        end
    end

    `include "ipv4_udp_header_generator_core_assert.svh"

    `IUHG_ASSERT(a_pid_step, s2_load |=> r_pid == $past(r_pid) + 16'd1, "packet id did not step")
    `IUHG_ASSERT(a_s2_hold, (r_s2_vld && !i_load) |=> r_s2_vld, "built header was dropped")
    `IUHG_NEVER(a_load_empty, i_load && !r_s2_vld, "serializer loaded an empty stage")

endmodule

FILE: design/iuhg_ser.sv
// ----------------------------------------------------------------------------
// Header serializer
// Holds one finished header in a shift register and sends it one byte per
// transaction, flagging the final byte.
// ----------------------------------------------------------------------------
module iuhg_ser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_hdr_vld,
    input  logic [iuhg_pkg::HDR_W-1:0]    i_hdr,
    output logic                          o_load,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output iuhg_pkg::t_rsp                o_out_data
);

    logic                              r_busy;
    logic [iuhg_pkg::HDR_W-1:0]        r_shift;
    logic [iuhg_pkg::CNT_W-1:0]        r_cnt;

    logic                              out_fire;
    logic                              last_done;

    assign out_fire  = r_busy && !i_out_stall;
    assign last_done = out_fire && (r_cnt == iuhg_pkg::LAST_IDX);
    // A new header may enter in the same cycle the final byte leaves.
    assign o_load    = i_hdr_vld && (!r_busy || last_done);

    assign o_out_valid            = r_busy;
    assign o_out_data.header_byte = r_shift[iuhg_pkg::HDR_W-1 -: 8];
    assign o_out_data.last_byte   = (r_cnt == iuhg_pkg::LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (o_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (last_done) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else if (out_fire) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_shift <= i_hdr;
        end else if (out_fire) begin
            r_shift <= {r_shift[iuhg_pkg::HDR_W-9:0], 8'h00};
        end
    end

    `include "ipv4_udp_header_generator_core_assert.svh"

    `IUHG_ASSERT(a_cnt_step, (out_fire && !last_done) |=> r_cnt == $past(r_cnt) + 1'b1, "miscount")
    `IUHG_ASSERT(a_end_idle, (last_done && !o_load) |=> !r_busy, "still busy after last byte")
    `IUHG_NEVER(a_cnt_range, r_busy && (r_cnt > iuhg_pkg::LAST_IDX), "byte count beyond header")

endmodule

FILE: design/ipv4_udp_header_generator_core.sv
// ----------------------------------------------------------------------------
// IPv4/UDP header generator core
// Turns each datagram request into the 28-byte IPv4 plus UDP header, sent
// one byte per transaction in wire order with the IPv4 checksum filled in.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Carries
//  in        input      i_in_valid/o_in_stall  t_req: length, addresses, ports
//  out       output     o_out_valid/i_out_stall t_rsp: header byte, last flag
//  cfg       input      i_cfg_valid/o_cfg_ready DSCP value (6 bits)
//
// A request passes through the input register, the header register and the
// serializer shift register before its first byte appears; the serializer then
// sends one byte per cycle while i_out_stall is low, so throughput is set by the
// one-byte output port. The next request is built while the current header
// drains. Reset clears the packet id, the DSCP value and all valid flags.
// A stall on the output holds the current byte and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module ipv4_udp_header_generator_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  iuhg_pkg::t_req   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output iuhg_pkg::t_rsp   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [5:0]       i_cfg_data
);

    logic [5:0]                      r_dscp;
    logic                            hdr_vld;
    logic [iuhg_pkg::HDR_W-1:0]      hdr;
    logic                            hdr_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dscp <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dscp <= i_cfg_data;
        end
    end

    iuhg_hdr_build u_build (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_dscp     (r_dscp),
        .o_hdr_vld  (hdr_vld),
        .o_hdr      (hdr),
        .i_load     (hdr_load)
    );

    iuhg_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_vld   (hdr_vld),
        .i_hdr       (hdr),
        .o_load      (hdr_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
